@@ rtl/bffa_pkg.sv @@
// ----------------------------------------------------------------------------
// Bitmap first-fit allocator package
// Shared constants, status and opcode codes, and the search step structs.
// ----------------------------------------------------------------------------
package bffa_pkg;

   // Pool geometry
   localparam int BLOCK_BYTES = 64;
   localparam int BLK_SHIFT   = 6;
   localparam int MAX_BLOCKS  = 1024;
   localparam int IDX_W       = 10;
   localparam int CNT_W       = 11;
   localparam int CHUNK_W     = 8;
   localparam int CHUNK_N     = MAX_BLOCKS / CHUNK_W;
   localparam int CHUNK_AW    = 7;
   localparam int CHUNK_BW    = 3;

   // Opcodes
   localparam logic [1:0] OP_ALLOC = 2'd0;
   localparam logic [1:0] OP_FREE  = 2'd1;
   localparam logic [1:0] OP_QUERY = 2'd2;

   // Status codes
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_INV_SIZE  = 3'd1;
   localparam logic [2:0] ST_EXHAUSTED = 3'd2;
   localparam logic [2:0] ST_NULL      = 3'd3;
   localparam logic [2:0] ST_RANGE     = 3'd4;
   localparam logic [2:0] ST_CORRUPT   = 3'd5;
   localparam logic [2:0] ST_NOT_ALLOC = 3'd6;

   // Register indexes
   localparam logic REG_POOL_BASE   = 1'b0;
   localparam logic REG_POOL_BLOCKS = 1'b1;

   // One search step over a bitmap chunk
   typedef struct packed {
      logic [CHUNK_AW-1:0] chunk_idx;
      logic [CHUNK_W-1:0]  data;
      logic [CNT_W-1:0]    run_cnt;
      logic [CNT_W-1:0]    run_start;
      logic [CNT_W-1:0]    need;
      logic [CNT_W-1:0]    n;
   } scan_in_type;

   typedef struct packed {
      logic [CNT_W-1:0] run_cnt;
      logic [CNT_W-1:0] run_start;
      logic             found;
      logic [IDX_W-1:0] start;
   } scan_out_type;

endpackage

@@ rtl/bffa_ram.sv @@
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module bffa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128,
   parameter int AW    = 7
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ rtl/bffa_scan.sv @@
// ----------------------------------------------------------------------------
// First-fit search step
// Walks one bitmap chunk, extending or restarting the current free run.
// ----------------------------------------------------------------------------
module bffa_scan (
   input  bffa_pkg::scan_in_type  scan_in,
   output bffa_pkg::scan_out_type scan_out
);

   // Blocks at or beyond the pool end count as used.
   always_comb begin
      logic [bffa_pkg::CNT_W-1:0] cnt;
      logic [bffa_pkg::CNT_W-1:0] st;
      logic [bffa_pkg::IDX_W-1:0] bi;
      logic                       used;
      logic                       fnd;
      logic [bffa_pkg::IDX_W-1:0] fst;
      cnt  = scan_in.run_cnt;
      st   = scan_in.run_start;
      fnd  = 1'b0;
      fst  = '0;
      bi   = '0;
      used = 1'b0;
      for (int b = 0; b < bffa_pkg::CHUNK_W; b++) begin
         bi   = {scan_in.chunk_idx, bffa_pkg::CHUNK_BW'(b)};
         used = scan_in.data[b] | ({1'b0, bi} >= scan_in.n);
         if (used) begin
            cnt = '0;
            st  = {1'b0, bi} + 11'd1;
         end else begin
            cnt = cnt + 11'd1;
         end
         if (!fnd && cnt == scan_in.need) begin
            fnd = 1'b1;
            fst = st[bffa_pkg::IDX_W-1:0];
         end
      end
      scan_out.run_cnt   = cnt;
      scan_out.run_start = st;
      scan_out.found     = fnd;
      scan_out.start     = fst;
   end

endmodule

@@ rtl/bitmap_first_fit_block_allocator.sv @@
// ----------------------------------------------------------------------------
// Bitmap first-fit block allocator
// Allocates, frees and queries runs of 64-byte blocks in a 1024-block pool.
// ----------------------------------------------------------------------------
// Usage:
//  Requests arrive as beats on the req_ channel: tuser carries the opcode
//  (allocate, free, query), tdata the byte size and the block address.
//  Each request gives exactly one response beat on the rsp_ channel with
//  the status, base address, first block index and run length.
//  The csr_ channel writes pool_base (index 0) and pool_blocks (index 1);
//  it is always ready and should only be written while the block is idle.
//  One request is handled at a time. Checks that fail go straight to the
//  output state; query and the run-length check first read the run-length
//  RAM. Allocate scans the bitmap 8 blocks per cycle, one chunk per read
//  of the registered bitmap RAM, up to the last chunk (an exhausted pool
//  answers then), and then marks the run with a read and a write per
//  bitmap chunk touched; free does the same marking after its run-length
//  lookup. The bitmap RAM port sets the scan rate.
//  After reset a clearing pass over every run-length entry zeroes both
//  memories, with req_tready low; configuration writes are taken meanwhile.
//  A response waits in its output register while rsp_tready is low. One
//  further request is taken and handled meanwhile; its response then waits
//  and later requests are held off until the waiting beat is taken.
// ----------------------------------------------------------------------------
module bitmap_first_fit_block_allocator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,  // size_bytes[31:0], address[63:32]
   input  logic [1:0]  req_tuser,  // op[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,  // status[2:0], block_address[34:3],
                                   // run_index[44:35], block_count[55:45]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [31:0] csr_data
);

   localparam logic [2:0] S_CLEAR   = 3'd0;
   localparam logic [2:0] S_IDLE    = 3'd1;
   localparam logic [2:0] S_SCAN    = 3'd2;
   localparam logic [2:0] S_LEN     = 3'd3;
   localparam logic [2:0] S_MARK_RD = 3'd4;
   localparam logic [2:0] S_MARK_WR = 3'd5;
   localparam logic [2:0] S_OUT     = 3'd6;

   localparam int IW = bffa_pkg::IDX_W;
   localparam int CW = bffa_pkg::CNT_W;
   localparam int AW = bffa_pkg::CHUNK_AW;

   logic [2:0]    state_ff, state_in;
   logic [IW-1:0] clr_ff, clr_in;
   logic [AW-1:0] ptr_ff, ptr_in;
   logic          chunk_vld_ff, chunk_vld_in;
   logic [AW-1:0] chunk_idx_ff, chunk_idx_in;
   logic [CW-1:0] run_cnt_ff, run_cnt_in;
   logic [CW-1:0] run_start_ff, run_start_in;
   logic [CW-1:0] need_ff, need_in;
   logic [IW-1:0] lo_ff, lo_in;
   logic [IW-1:0] hi_ff, hi_in;
   logic          set_ff, set_in;
   logic [1:0]    op_ff, op_in;
   logic [2:0]    res_st_ff, res_st_in;
   logic [31:0]   res_addr_ff, res_addr_in;
   logic [IW-1:0] res_idx_ff, res_idx_in;
   logic [CW-1:0] res_cnt_ff, res_cnt_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [55:0]   rsp_data_ff, rsp_data_in;
   logic [31:0]   base_ff, base_in;
   logic [CW-1:0] blocks_ff, blocks_in;

   logic [CW-1:0] n;
   logic [31:0]   size_bytes;
   logic [31:0]   address;
   logic [26:0]   need_req;
   logic [32:0]   pool_end;
   logic [31:0]   offset;
   logic [IW-1:0] req_idx;

   logic                   bm_we;
   logic [AW-1:0]          bm_waddr;
   logic [7:0]             bm_wdata;
   logic [7:0]             bm_rdata;
   logic                   len_we;
   logic [IW-1:0]          len_waddr;
   logic [CW-1:0]          len_wdata;
   logic [IW-1:0]          len_raddr;
   logic [CW-1:0]          len_rdata;
   logic [7:0]             mark_mask;
   logic [CW-1:0]          run_end;
   logic [CW:0]            free_end;

   bffa_pkg::scan_in_type  scan_in;
   bffa_pkg::scan_out_type scan_out;

   // Request fields and derived quantities.
   assign size_bytes = req_tdata[31:0];
   assign address    = req_tdata[63:32];
   assign n          = (blocks_ff > CW'(bffa_pkg::MAX_BLOCKS)) ?
                       CW'(bffa_pkg::MAX_BLOCKS) : blocks_ff;
   assign need_req   = {1'b0, size_bytes[31:bffa_pkg::BLK_SHIFT]} +
                       27'(|size_bytes[bffa_pkg::BLK_SHIFT-1:0]);
   assign pool_end   = {1'b0, base_ff} + {16'd0, n, 6'd0};
   assign offset     = address - base_ff;
   assign req_idx    = offset[IW+bffa_pkg::BLK_SHIFT-1:bffa_pkg::BLK_SHIFT];
   assign free_end   = {2'b00, lo_ff} + {1'b0, len_rdata};

   // Memories: used bitmap in 8-bit chunks and run lengths.
   bffa_ram #(.WIDTH(8), .DEPTH(bffa_pkg::CHUNK_N), .AW(AW)) u_bitmap (
      .clock (clock),
      .we    (bm_we),
      .waddr (bm_waddr),
      .wdata (bm_wdata),
      .raddr (ptr_ff),
      .rdata (bm_rdata)
   );

   bffa_ram #(.WIDTH(CW), .DEPTH(bffa_pkg::MAX_BLOCKS), .AW(IW)) u_runlen (
      .clock (clock),
      .we    (len_we),
      .waddr (len_waddr),
      .wdata (len_wdata),
      .raddr (len_raddr),
      .rdata (len_rdata)
   );

   // Search step over the chunk that arrived from the bitmap.
   assign scan_in.chunk_idx = chunk_idx_ff;
   assign scan_in.data      = bm_rdata;
   assign scan_in.run_cnt   = run_cnt_ff;
   assign scan_in.run_start = run_start_ff;
   assign scan_in.need      = need_ff;
   assign scan_in.n         = n;

   bffa_scan u_scan (
      .scan_in  (scan_in),
      .scan_out (scan_out)
   );

   // Mask of the run's bits within the chunk being marked.
   always_comb begin
      logic [IW-1:0] bi;
      bi = '0;
      for (int b = 0; b < bffa_pkg::CHUNK_W; b++) begin
         bi           = {ptr_ff, bffa_pkg::CHUNK_BW'(b)};
         mark_mask[b] = (bi >= lo_ff) && (bi <= hi_ff);
      end
   end

   assign run_end   = {1'b0, scan_out.start} + need_ff - 11'd1;
   assign len_raddr = req_idx;

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      ptr_in       = ptr_ff;
      chunk_vld_in = chunk_vld_ff;
      chunk_idx_in = chunk_idx_ff;
      run_cnt_in   = run_cnt_ff;
      run_start_in = run_start_ff;
      need_in      = need_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      set_in       = set_ff;
      op_in        = op_ff;
      res_st_in    = res_st_ff;
      res_addr_in  = res_addr_ff;
      res_idx_in   = res_idx_ff;
      res_cnt_in   = res_cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      bm_we        = 1'b0;
      bm_waddr     = ptr_ff;
      bm_wdata     = set_ff ? (bm_rdata | mark_mask) : (bm_rdata & ~mark_mask);
      len_we       = 1'b0;
      len_waddr    = lo_ff;
      len_wdata    = set_ff ? need_ff : '0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_CLEAR: begin
            bm_we     = 1'b1;
            bm_waddr  = clr_ff[AW-1:0];
            bm_wdata  = '0;
            len_we    = 1'b1;
            len_waddr = clr_ff;
            len_wdata = '0;
            clr_in    = clr_ff + 10'd1;
            if (clr_ff == IW'(bffa_pkg::MAX_BLOCKS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               op_in       = req_tuser;
               res_st_in   = bffa_pkg::ST_OK;
               res_addr_in = '0;
               res_idx_in  = '0;
               res_cnt_in  = '0;
               state_in    = S_OUT;
               if (req_tuser == bffa_pkg::OP_ALLOC) begin
                  if (size_bytes == '0) begin
                     res_st_in = bffa_pkg::ST_INV_SIZE;
                  end else if (need_req > {16'd0, n}) begin
                     res_st_in = bffa_pkg::ST_EXHAUSTED;
                  end else begin
                     need_in      = need_req[CW-1:0];
                     run_cnt_in   = '0;
                     run_start_in = '0;
                     chunk_vld_in = 1'b0;
                     ptr_in       = '0;
                     state_in     = S_SCAN;
                  end
               end else if (req_tuser == bffa_pkg::OP_FREE ||
                            req_tuser == bffa_pkg::OP_QUERY) begin
                  if (address == '0) begin
                     res_st_in = bffa_pkg::ST_NULL;
                  end else if (address < base_ff || {1'b0, address} >= pool_end) begin
                     res_st_in = bffa_pkg::ST_RANGE;
                  end else if (|offset[bffa_pkg::BLK_SHIFT-1:0]) begin
                     res_st_in = bffa_pkg::ST_CORRUPT;
                  end else begin
                     lo_in    = req_idx;
                     state_in = S_LEN;
                  end
               end
            end
         end
         S_SCAN: begin
            chunk_vld_in = 1'b1;
            chunk_idx_in = ptr_ff;
            ptr_in       = ptr_ff + 7'd1;
            if (chunk_vld_ff) begin
               run_cnt_in   = scan_out.run_cnt;
               run_start_in = scan_out.run_start;
               if (scan_out.found) begin
                  lo_in       = scan_out.start;
                  hi_in       = run_end[IW-1:0];
                  ptr_in      = scan_out.start[IW-1:bffa_pkg::CHUNK_BW];
                  set_in      = 1'b1;
                  res_idx_in  = scan_out.start;
                  res_cnt_in  = need_ff;
                  res_addr_in = base_ff + {16'd0, scan_out.start, 6'd0};
                  state_in    = S_MARK_RD;
               end else if (chunk_idx_ff == AW'(bffa_pkg::CHUNK_N - 1)) begin
                  res_st_in = bffa_pkg::ST_EXHAUSTED;
                  state_in  = S_OUT;
               end
            end
         end
         S_LEN: begin
            state_in = S_OUT;
            if (len_rdata == '0) begin
               res_st_in = bffa_pkg::ST_NOT_ALLOC;
            end else if (op_ff == bffa_pkg::OP_QUERY) begin
               res_idx_in = lo_ff;
               res_cnt_in = len_rdata;
            end else if (free_end > {1'b0, n}) begin
               res_st_in = bffa_pkg::ST_CORRUPT;
            end else begin
               need_in    = len_rdata;
               hi_in      = lo_ff + len_rdata[IW-1:0] - 10'd1;
               ptr_in     = lo_ff[IW-1:bffa_pkg::CHUNK_BW];
               set_in     = 1'b0;
               res_idx_in = lo_ff;
               res_cnt_in = len_rdata;
               state_in   = S_MARK_RD;
            end
         end
         S_MARK_RD: begin
            state_in = S_MARK_WR;
         end
         S_MARK_WR: begin
            bm_we = 1'b1;
            if (ptr_ff == hi_ff[IW-1:bffa_pkg::CHUNK_BW]) begin
               len_we   = 1'b1;
               state_in = S_OUT;
            end else begin
               ptr_in   = ptr_ff + 7'd1;
               state_in = S_MARK_RD;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {res_cnt_ff, res_idx_ff, res_addr_ff, res_st_ff};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Configuration writes.
   always_comb begin
      base_in   = base_ff;
      blocks_in = blocks_ff;
      if (csr_valid) begin
         unique case (csr_index)
            bffa_pkg::REG_POOL_BASE:   base_in   = csr_data;
            bffa_pkg::REG_POOL_BLOCKS: blocks_in = csr_data[CW-1:0];
            default:                   base_in   = base_ff;
         endcase
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         chunk_vld_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         base_ff      <= '0;
         blocks_ff    <= CW'(bffa_pkg::MAX_BLOCKS);
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         chunk_vld_ff <= chunk_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         base_ff      <= base_in;
         blocks_ff    <= blocks_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      ptr_ff       <= ptr_in;
      chunk_idx_ff <= chunk_idx_in;
      run_cnt_ff   <= run_cnt_in;
      run_start_ff <= run_start_in;
      need_ff      <= need_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      set_ff       <= set_in;
      op_ff        <= op_in;
      res_st_ff    <= res_st_in;
      res_addr_ff  <= res_addr_in;
      res_idx_ff   <= res_idx_in;
      res_cnt_ff   <= res_cnt_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign csr_ready  = 1'b1;

   // A request beat keeps the block busy in the next cycle.
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while a request is in progress");

   // No request is taken in the first cycle after reset.
   a_clear_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !req_tready)
      else $error("request taken before the clearing pass");

   // Failed requests report no address, index or length.
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2:0] != bffa_pkg::ST_OK |-> rsp_tdata[55:3] == '0)
      else $error("failed response carries run fields");

   // A beat waiting on the output only leaves with rsp_tready.
   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response beat dropped or changed while stalled");

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap first-fit block allocator testbench
// Drives allocate, free and query beats through the request stream with
// random gaps and stalls, and rewrites the pool registers between phases.
// A scoreboard tracks the bitmap and the run lengths itself and checks every
// response beat, field by field, against its own prediction.
// ----------------------------------------------------------------------------

// One predicted response
typedef struct {
   logic [2:0]  status;
   logic [31:0] block_address;
   logic [9:0]  run_index;
   logic [10:0] block_count;
} alloc_answer_type;

class alloc_scoreboard;
   bit          used_map[bffa_pkg::MAX_BLOCKS];
   bit   [10:0] run_len[bffa_pkg::MAX_BLOCKS];
   bit   [31:0] pool_base;
   bit   [10:0] pool_blocks;
   alloc_answer_type answers[$];
   bit   [31:0] live_addrs[$];
   int          errors;

   function new();
      pool_base   = 0;
      pool_blocks = 11'd1024;
      errors      = 0;
      foreach (used_map[i]) begin
         used_map[i] = 0;
         run_len[i]  = 0;
      end
   endfunction

   function void write_reg(logic idx, logic [31:0] value);
      if (idx == bffa_pkg::REG_POOL_BASE)
         pool_base = value;
      else
         pool_blocks = value[10:0];
   endfunction

   function int unsigned live_count();
      return (pool_blocks < bffa_pkg::MAX_BLOCKS) ? pool_blocks : bffa_pkg::MAX_BLOCKS;
   endfunction

   // First-fit search and marking of a new run
   function alloc_answer_type allocate(logic [31:0] size);
      alloc_answer_type a;
      int unsigned n, need, idx, j;
      longint unsigned need64;
      a = '{bffa_pkg::ST_EXHAUSTED, 0, 0, 0};
      n = live_count();
      if (size == 0) begin
         a.status = bffa_pkg::ST_INV_SIZE;
         return a;
      end
      need64 = (longint'(size) + bffa_pkg::BLOCK_BYTES - 1) / bffa_pkg::BLOCK_BYTES;
      if (need64 > n)
         return a;
      need = need64;
      idx  = 0;
      while (idx + need <= n) begin
         for (j = 0; j < need; j++)
            if (used_map[idx + j]) break;
         if (j == need) begin
            for (j = 0; j < need; j++) used_map[idx + j] = 1;
            run_len[idx] = need;
            a.status        = bffa_pkg::ST_OK;
            a.block_address = pool_base + idx * bffa_pkg::BLOCK_BYTES;
            a.run_index     = idx;
            a.block_count   = need;
            live_addrs.push_back(a.block_address);
            return a;
         end
         idx += j + 1;
      end
      return a;
   endfunction

   // Address checks shared by free and query
   function alloc_answer_type free_or_query(logic [31:0] addr, bit release_run);
      alloc_answer_type a;
      longint unsigned pool_end, off;
      int unsigned n, idx, len, j;
      a = '{bffa_pkg::ST_OK, 0, 0, 0};
      n = live_count();
      pool_end = longint'(pool_base) + longint'(n) * bffa_pkg::BLOCK_BYTES;
      if (addr == 0) begin
         a.status = bffa_pkg::ST_NULL;
         return a;
      end
      if (addr < pool_base || longint'(addr) >= pool_end) begin
         a.status = bffa_pkg::ST_RANGE;
         return a;
      end
      off = addr - pool_base;
      if (off % bffa_pkg::BLOCK_BYTES != 0) begin
         a.status = bffa_pkg::ST_CORRUPT;
         return a;
      end
      idx = off / bffa_pkg::BLOCK_BYTES;
      len = run_len[idx];
      if (len == 0) begin
         a.status = bffa_pkg::ST_NOT_ALLOC;
         return a;
      end
      if (release_run) begin
         // A run reaching past a shrunken pool is left alone
         if (idx + len > n) begin
            a.status = bffa_pkg::ST_CORRUPT;
            return a;
         end
         for (j = 0; j < len; j++) used_map[idx + j] = 0;
         run_len[idx] = 0;
         foreach (live_addrs[k])
            if (live_addrs[k] == addr) begin
               live_addrs.delete(k);
               break;
            end
      end
      a.run_index   = idx;
      a.block_count = len;
      return a;
   endfunction

   // Called for every accepted request beat
   function void note_request(logic [1:0] op, logic [31:0] size, logic [31:0] addr);
      alloc_answer_type a;
      case (op)
         bffa_pkg::OP_ALLOC: a = allocate(size);
         bffa_pkg::OP_FREE:  a = free_or_query(addr, 1);
         bffa_pkg::OP_QUERY: a = free_or_query(addr, 0);
         default:            a = '{bffa_pkg::ST_OK, 0, 0, 0};
      endcase
      answers.push_back(a);
   endfunction

   // Called for every accepted response beat
   function void check_result(logic [55:0] data);
      alloc_answer_type e;
      if (answers.size() == 0) begin
         $display("%0t: response beat %h with nothing expected", $time, data);
         errors++;
         return;
      end
      e = answers.pop_front();
      if (data[2:0] !== e.status) begin
         $display("%0t: status expected %0d, got %0d", $time, e.status, data[2:0]);
         errors++;
      end
      if (data[34:3] !== e.block_address) begin
         $display("%0t: block_address expected %h, got %h", $time,
                  e.block_address, data[34:3]);
         errors++;
      end
      if (data[44:35] !== e.run_index) begin
         $display("%0t: run_index expected %0d, got %0d", $time,
                  e.run_index, data[44:35]);
         errors++;
      end
      if (data[55:45] !== e.block_count) begin
         $display("%0t: block_count expected %0d, got %0d", $time,
                  e.block_count, data[55:45]);
         errors++;
      end
   endfunction
endclass

module testbench;
   localparam logic [1:0] OP_UNUSED  = 2'd3;
   localparam int         STALL_LONG = 300;
   localparam int         IDLE_LIMIT = 6000;

   logic        clock      = 0;
   logic        reset      = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [63:0] req_tdata  = '0;  // size_bytes[31:0], address[63:32]
   logic [1:0]  req_tuser  = '0;  // op[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [55:0] rsp_tdata;        // status[2:0], block_address[34:3],
                                  // run_index[44:35], block_count[55:45]
   logic        csr_valid  = 0;
   logic        csr_ready;
   logic        csr_index  = 0;
   logic [31:0] csr_data   = '0;

   alloc_scoreboard sb = new();
   bit no_gaps    = 0;
   bit hold_rsp   = 0;
   int idle_count = 0;

   bitmap_first_fit_block_allocator uut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   function int draw_gap();
      return no_gaps ? 0 : $urandom_range(0, 16);
   endfunction

   // Response side: random stalls, and one long hold-off on request
   initial begin
      int gap;
      @(posedge clock);
      forever begin
         gap = hold_rsp ? STALL_LONG : draw_gap();
         hold_rsp = 0;
         if (gap > 0) begin
            rsp_tready <= 0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1;
         do @(posedge clock); while (!rsp_tvalid);
         sb.check_result(rsp_tdata);
      end
   end

   // Watchdog on cycles without any accepted beat
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         idle_count <= 0;
      else
         idle_count <= idle_count + 1;
      if (idle_count >= IDLE_LIMIT) begin
         $display("[bitmap_first_fit_block_allocator] ERROR");
         $finish;
      end
   end

   // One request beat; valid stays high for a back-to-back successor
   task send(logic [1:0] op, logic [31:0] size, logic [31:0] addr);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser  <= op;
      req_tdata  <= {addr, size};
      do @(posedge clock); while (!req_tready);
      sb.note_request(op, size, addr);
   endtask

   task wait_idle();
      req_tvalid <= 0;
      while (sb.answers.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Both pool registers in two consecutive beats
   task write_regs(logic [31:0] base, logic [31:0] blocks);
      csr_valid <= 1;
      csr_index <= bffa_pkg::REG_POOL_BASE;
      csr_data  <= base;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(bffa_pkg::REG_POOL_BASE, base);
      csr_index <= bffa_pkg::REG_POOL_BLOCKS;
      csr_data  <= blocks;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(bffa_pkg::REG_POOL_BLOCKS, blocks);
      csr_valid <= 0;
   endtask

   task set_pool(logic [31:0] base, logic [31:0] blocks);
      wait_idle();
      write_regs(base, blocks);
   endtask

   // Release every run still tracked as live
   task free_all();
      bit [31:0] snap[$];
      snap = sb.live_addrs;
      foreach (snap[i]) send(bffa_pkg::OP_FREE, 0, snap[i]);
   endtask

   // Mostly well-formed traffic on live runs, with some noise
   task random_item();
      int unsigned pick, n;
      logic [31:0] size, addr;
      pick = $urandom_range(0, 99);
      n    = sb.live_count();
      size = $urandom();
      case ($urandom_range(0, 19))
         0:             addr = 0;
         1, 2:          addr = $urandom();
         3, 4, 5:       addr = sb.pool_base
                               + $urandom_range(0, n + 2) * bffa_pkg::BLOCK_BYTES
                               + $urandom_range(0, 1) * $urandom_range(1, 63);
         default: begin
            if (sb.live_addrs.size() != 0)
               addr = sb.live_addrs[$urandom_range(0, sb.live_addrs.size() - 1)];
            else
               addr = sb.pool_base + $urandom_range(0, n) * bffa_pkg::BLOCK_BYTES;
         end
      endcase
      if (pick < 45) begin
         case ($urandom_range(0, 19))
            0:             size = 0;
            1, 2:          size = $urandom();
            3, 4, 5, 6:    size = $urandom_range(1, 64 * 64);
            default:       size = $urandom_range(1, 512);
         endcase
         send(bffa_pkg::OP_ALLOC, size, addr);
      end else if (pick < 75)
         send(bffa_pkg::OP_FREE, size, addr);
      else if (pick < 92)
         send(bffa_pkg::OP_QUERY, size, addr);
      else
         send(OP_UNUSED, size, addr);
   endtask

   task random_phase(int count);
      repeat (count) random_item();
      free_all();
   endtask

   initial begin
      logic [31:0] b;
      repeat (11) @(posedge clock);
      reset <= 0;

      // Directed checks on a pool at 0x1000
      write_regs(32'h1000, 1024);
      b = 32'h1000;
      send(bffa_pkg::OP_ALLOC, 0, 0);
      send(bffa_pkg::OP_ALLOC, 32'hFFFF_FFFF, 0);
      send(bffa_pkg::OP_ALLOC, 1, 32'hFFFF_FFFF);
      send(bffa_pkg::OP_ALLOC, 65, 0);
      send(bffa_pkg::OP_ALLOC, 64, 0);
      send(bffa_pkg::OP_ALLOC, 64 * 1024, 0);
      send(bffa_pkg::OP_QUERY, 0, b);
      send(bffa_pkg::OP_QUERY, 0, b + 1);
      send(bffa_pkg::OP_QUERY, 0, 0);
      send(bffa_pkg::OP_QUERY, 0, b - 64);
      send(bffa_pkg::OP_QUERY, 0, b + 1024 * 64);
      send(bffa_pkg::OP_QUERY, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send(bffa_pkg::OP_QUERY, 0, b + 2 * 64);
      send(bffa_pkg::OP_FREE, 0, b + 64);
      send(bffa_pkg::OP_FREE, 0, b + 64);
      send(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send(bffa_pkg::OP_ALLOC, 128, 0);
      send(bffa_pkg::OP_ALLOC, 129, 0);
      send(bffa_pkg::OP_ALLOC, 64 * 500, 0);

      // A run that ends past a shrunken pool
      set_pool(b, 100);
      send(bffa_pkg::OP_FREE, 0, b + 7 * 64);
      send(bffa_pkg::OP_QUERY, 0, b + 7 * 64);
      send(bffa_pkg::OP_ALLOC, 64 * 200, 0);
      set_pool(b, 1024);
      free_all();

      // Random phases over several pool settings
      random_phase(70);
      set_pool(0, 1024);
      no_gaps = 1;
      random_phase(60);
      no_gaps = 0;
      set_pool($urandom(), 1);
      random_phase(40);
      set_pool(32'hFFFF_FF00, 16);
      random_phase(50);
      set_pool($urandom() & ~32'h3F, $urandom_range(1, 1024));
      random_phase(40);
      // Long receiver hold-off while requests keep coming
      hold_rsp = 1;
      repeat (12) random_item();
      random_phase(40);
      set_pool(32'hFFFF_0000, 1024);
      random_phase(60);
      set_pool($urandom(), $urandom_range(1, 1024));
      random_phase(40);

      wait_idle();
      repeat (200) @(posedge clock);
      if (sb.errors == 0)
         $display("[bitmap_first_fit_block_allocator] OK");
      else
         $display("[bitmap_first_fit_block_allocator] ERROR");
      $finish;
   end
endmodule
